// ----- src/assert_macros.svh -----
// Assertion helpers for the block's concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is asserted.
`define SFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define SFA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");

`endif

// ----- src/sfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_pkg
// Number formats, widths, register indexes and transaction types of the
// spring force accumulator.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  localparam int CFG_BITS     = 31;
  localparam int CFG_IDX_BITS = 1;

  localparam int DB   = WORD_BITS + 1;                 // |d| width
  localparam int LB   = DB;                            // spring length width
  localparam int SB   = 2 * DB;                        // sum of squares width
  localparam int AEB  = (LB > CFG_BITS) ? LB : CFG_BITS; // |L - R| width
  localparam int TB   = AEB;                           // quotient width
  localparam int NB   = DB + AEB;                      // dividend width
  localparam int MB   = WORD_BITS + 1;                 // clamped increment
  localparam int SUMB = WORD_BITS + 2;                 // force sum width

  localparam logic [CFG_BITS-1:0] K_RESET = CFG_BITS'(64'd1 << FRAC_BITS);
  localparam logic [CFG_BITS-1:0] R_RESET = CFG_BITS'(64'd1 << FRAC_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SPRING_CONSTANT = 1'b0,
    CFG_REST_LENGTH     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
    logic signed [WORD_BITS-1:0] end_x;
    logic signed [WORD_BITS-1:0] end_y;
    logic signed [WORD_BITS-1:0] end_z;
    logic signed [WORD_BITS-1:0] force_in_x;
    logic signed [WORD_BITS-1:0] force_in_y;
    logic signed [WORD_BITS-1:0] force_in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] force_out_x;
    logic signed [WORD_BITS-1:0] force_out_y;
    logic signed [WORD_BITS-1:0] force_out_z;
    logic                        saturated;
  } out_item_t;

  // Per-component data carried alongside the length and divide chains.
  typedef struct packed {
    logic [2:0]                dneg;
    logic [2:0][DB-1:0]        ad;
    logic [2:0][WORD_BITS-1:0] f;
  } side_t;

endpackage

// ----- src/spring_force_accumulate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_force_accumulate
// Hooke's law spring force added to an accumulated force, signed fixed point,
// fully pipelined: difference, squares, bit-serial square root stages,
// partial-product multiply, one-bit-per-stage divide, stiffness multiply,
// saturating add.
// ----------------------------------------------------------------------------
// channel   direction  transaction
// item      in         start_i && !busy_o, payload item_i
// result    out        done_o for one cycle, payload result_o
// config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle; data are in Q16.16. The square root and divide
// chains each produce one result bit per stage.
// busy_o is never raised. Reset clears all valid bits and sets both
// registers to 1.0. Results cannot be held off and nothing stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spring_force_accumulate
  import sfa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  in_item_t                item_i,
  output logic                    done_o,
  output out_item_t               result_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i
);

  localparam int WB   = WORD_BITS;
  localparam int AHLO = AEB / 2;
  localparam int KLO  = CFG_BITS / 2;
  localparam int PB   = TB + CFG_BITS;
  localparam int PSB  = PB - FRAC_BITS;
  localparam int LAT  = 9 + LB + TB;

  localparam logic [PSB-1:0]         M_LIM = PSB'(1) << WB;
  localparam logic signed [SUMB-1:0] S_MAX = {3'b000, {(WB-1){1'b1}}};
  localparam logic signed [SUMB-1:0] S_MIN = {3'b111, {(WB-1){1'b0}}};

  logic [CFG_BITS-1:0] k_q, r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_RESET;
      r_q <= R_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPRING_CONSTANT: k_q <= cfg_wdata_i;
        CFG_REST_LENGTH:     r_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage registers
  logic v0_q, v1_q, ev_q, pv_q, kv_q, mv_q, done_q;
  side_t side0_d, side0_q, side1_q, eside_q, pside_q, kside_q, mside_q;
  logic [SB-1:0] sq1_q [3];

  logic          sv_q    [LB+1];
  side_t         sside_q [LB+1], sside_d [LB+1];
  logic [SB-1:0] ss_q    [LB+1], ss_d    [LB+1];
  logic [LB+1:0] srem_q  [LB+1], srem_d  [LB+1];
  logic [LB-1:0] sroot_q [LB+1], sroot_d [LB+1];

  logic [LB-1:0]  elen_q;
  logic           elz_q, eneg_q;
  logic [AEB-1:0] ae_q;

  logic [LB-1:0]           plen_q;
  logic                    plz_q, pneg_q;
  logic [DB+AHLO-1:0]      plo_q [3];
  logic [DB+AEB-AHLO-1:0]  phi_q [3];

  logic          dv_q    [TB+1];
  side_t         dside_q [TB+1];
  logic [LB-1:0] dlen_q  [TB+1];
  logic          dlz_q   [TB+1], dneg_q [TB+1];
  logic [LB-1:0] drem_q  [TB+1][3], drem_d [TB+1][3];
  logic [TB-1:0] dnq_q   [TB+1][3], dnq_d  [TB+1][3];

  logic                         klz_q, kneg_q;
  logic [TB+KLO-1:0]            klo_q [3];
  logic [TB+CFG_BITS-KLO-1:0]   khi_q [3];

  logic          mlz_q, mneg_q;
  logic [MB-1:0] m_q [3], m_d [3];

  out_item_t result_q, result_d;

  // input stage
  logic signed [WB-1:0] pos_w [3], end_w [3], fin_w [3];
  assign pos_w[0] = item_i.pos_x;
  assign pos_w[1] = item_i.pos_y;
  assign pos_w[2] = item_i.pos_z;
  assign end_w[0] = item_i.end_x;
  assign end_w[1] = item_i.end_y;
  assign end_w[2] = item_i.end_z;
  assign fin_w[0] = item_i.force_in_x;
  assign fin_w[1] = item_i.force_in_y;
  assign fin_w[2] = item_i.force_in_z;

  always_comb begin
    logic [DB-1:0] dw;
    for (int c = 0; c < 3; c++) begin
      dw = {end_w[c][WB-1], end_w[c]} - {pos_w[c][WB-1], pos_w[c]};
      side0_d.dneg[c] = dw[DB-1];
      side0_d.ad[c]   = dw[DB-1] ? DB'(-dw) : dw;
      side0_d.f[c]    = fin_w[c];
    end
  end

  // square root steps
  always_comb begin
    logic [LB+1:0] cand, trial;
    sside_d[0] = side1_q;
    ss_d[0]    = SB'(sq1_q[0]) + SB'(sq1_q[1]) + SB'(sq1_q[2]);
    srem_d[0]  = '0;
    sroot_d[0] = '0;
    for (int k = 0; k < LB; k++) begin
      cand  = {srem_q[k][LB-1:0], ss_q[k][SB-1 -: 2]};
      trial = {sroot_q[k], 2'b01};
      sside_d[k+1] = sside_q[k];
      ss_d[k+1]    = {ss_q[k][SB-3:0], 2'b00};
      if (cand >= trial) begin
        srem_d[k+1]  = cand - trial;
        sroot_d[k+1] = {sroot_q[k][LB-2:0], 1'b1};
      end else begin
        srem_d[k+1]  = cand;
        sroot_d[k+1] = {sroot_q[k][LB-2:0], 1'b0};
      end
    end
  end

  // divide steps
  always_comb begin
    logic [NB-1:0] n;
    logic [LB:0]   cand;
    logic          ge;
    for (int c = 0; c < 3; c++) begin
      n = NB'(plo_q[c]) + (NB'(phi_q[c]) << AHLO);
      drem_d[0][c] = n[NB-1:TB];
      dnq_d[0][c]  = n[TB-1:0];
    end
    for (int k = 0; k < TB; k++) begin
      for (int c = 0; c < 3; c++) begin
        cand = {drem_q[k][c], dnq_q[k][c][TB-1]};
        ge   = cand >= {1'b0, dlen_q[k]};
        drem_d[k+1][c] = ge ? LB'(cand - {1'b0, dlen_q[k]}) : cand[LB-1:0];
        dnq_d[k+1][c]  = {dnq_q[k][c][TB-2:0], ge};
      end
    end
  end

  // increment clamp and saturating add
  always_comb begin
    logic [PB-1:0]          p;
    logic [PSB-1:0]         ps;
    logic signed [SUMB-1:0] s;
    logic signed [WB-1:0]   r [3];
    logic                   sat;
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      p  = PB'(klo_q[c]) + (PB'(khi_q[c]) << KLO);
      ps = p[PB-1:FRAC_BITS];
      m_d[c] = (ps > M_LIM) ? MB'(M_LIM) : ps[MB-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      if (mlz_q) begin
        s = SUMB'(0);
      end else if (mside_q.dneg[c] != mneg_q) begin
        s = $signed({{2{mside_q.f[c][WB-1]}}, mside_q.f[c]}) - $signed({1'b0, m_q[c]});
      end else begin
        s = $signed({{2{mside_q.f[c][WB-1]}}, mside_q.f[c]}) + $signed({1'b0, m_q[c]});
      end
      if (mlz_q) begin
        r[c] = mside_q.f[c];
      end else if (s > S_MAX) begin
        r[c] = {1'b0, {(WB-1){1'b1}}};
        sat  = 1'b1;
      end else if (s < S_MIN) begin
        r[c] = {1'b1, {(WB-1){1'b0}}};
        sat  = 1'b1;
      end else begin
        r[c] = s[WB-1:0];
      end
    end
    result_d.force_out_x = r[0];
    result_d.force_out_y = r[1];
    result_d.force_out_z = r[2];
    result_d.saturated   = sat;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      ev_q   <= 1'b0;
      pv_q   <= 1'b0;
      kv_q   <= 1'b0;
      mv_q   <= 1'b0;
      done_q <= 1'b0;
      for (int k = 0; k <= LB; k++) sv_q[k] <= 1'b0;
      for (int k = 0; k <= TB; k++) dv_q[k] <= 1'b0;
    end else begin
      v0_q    <= start_i && !busy_o;
      v1_q    <= v0_q;
      sv_q[0] <= v1_q;
      for (int k = 0; k < LB; k++) sv_q[k+1] <= sv_q[k];
      ev_q    <= sv_q[LB];
      pv_q    <= ev_q;
      dv_q[0] <= pv_q;
      for (int k = 0; k < TB; k++) dv_q[k+1] <= dv_q[k];
      kv_q    <= dv_q[TB];
      mv_q    <= kv_q;
      done_q  <= mv_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    side0_q <= side0_d;
    side1_q <= side0_q;
    for (int c = 0; c < 3; c++) sq1_q[c] <= SB'(side0_q.ad[c]) * SB'(side0_q.ad[c]);

    for (int k = 0; k <= LB; k++) begin
      sside_q[k] <= sside_d[k];
      ss_q[k]    <= ss_d[k];
      srem_q[k]  <= srem_d[k];
      sroot_q[k] <= sroot_d[k];
    end

    eside_q <= sside_q[LB];
    elen_q  <= sroot_q[LB];
    elz_q   <= (sroot_q[LB] == '0);
    begin
      logic signed [AEB:0] e;
      e = $signed({1'b0, AEB'(sroot_q[LB])}) - $signed({1'b0, AEB'(r_q)});
      eneg_q <= e[AEB];
      ae_q   <= e[AEB] ? AEB'(-e) : e[AEB-1:0];
    end

    pside_q <= eside_q;
    plen_q  <= elen_q;
    plz_q   <= elz_q;
    pneg_q  <= eneg_q;
    for (int c = 0; c < 3; c++) begin
      plo_q[c] <= (DB+AHLO)'(eside_q.ad[c]) * (DB+AHLO)'(ae_q[AHLO-1:0]);
      phi_q[c] <= (DB+AEB-AHLO)'(eside_q.ad[c]) * (DB+AEB-AHLO)'(ae_q[AEB-1:AHLO]);
    end

    dside_q[0] <= pside_q;
    dlen_q[0]  <= plen_q;
    dlz_q[0]   <= plz_q;
    dneg_q[0]  <= pneg_q;
    for (int k = 0; k < TB; k++) begin
      dside_q[k+1] <= dside_q[k];
      dlen_q[k+1]  <= dlen_q[k];
      dlz_q[k+1]   <= dlz_q[k];
      dneg_q[k+1]  <= dneg_q[k];
    end
    for (int k = 0; k <= TB; k++) begin
      for (int c = 0; c < 3; c++) begin
        drem_q[k][c] <= drem_d[k][c];
        dnq_q[k][c]  <= dnq_d[k][c];
      end
    end

    kside_q <= dside_q[TB];
    klz_q   <= dlz_q[TB];
    kneg_q  <= dneg_q[TB];
    for (int c = 0; c < 3; c++) begin
      klo_q[c] <= (TB+KLO)'(dnq_q[TB][c]) * (TB+KLO)'(k_q[KLO-1:0]);
      khi_q[c] <= (TB+CFG_BITS-KLO)'(dnq_q[TB][c]) *
                  (TB+CFG_BITS-KLO)'(k_q[CFG_BITS-1:KLO]);
    end

    mside_q <= kside_q;
    mlz_q   <= klz_q;
    mneg_q  <= kneg_q;
    for (int c = 0; c < 3; c++) m_q[c] <= m_d[c];

    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `SFA_ASSERT(a_latency, (start_i && !busy_o) |-> ##LAT done_o)
  `SFA_ASSERT(a_done_from_pipe, done_o |-> $past(mv_q))
  `SFA_ASSERT_ALWAYS(a_sat_clamped, (done_o && result_o.saturated) |->
    (result_o.force_out_x == {1'b0, {(WB-1){1'b1}}} ||
     result_o.force_out_x == {1'b1, {(WB-1){1'b0}}} ||
     result_o.force_out_y == {1'b0, {(WB-1){1'b1}}} ||
     result_o.force_out_y == {1'b1, {(WB-1){1'b0}}} ||
     result_o.force_out_z == {1'b0, {(WB-1){1'b1}}} ||
     result_o.force_out_z == {1'b1, {(WB-1){1'b0}}}))

endmodule
